// ===== rtl/erq_pkg.sv =====
// Package for the event ring queue: operation and status codes, field widths,
// default parameter values and the result struct passed between the control and output stages.
// No dependencies.
package erq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int EVENT_BITS_DEF = 32;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;

    // Capacity after reset, before clamping to the built depth.
    localparam int CAP_RESET = 16;

    localparam logic [OP_W-1:0] OP_FORCE_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_TRY_PUSH   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP        = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd3;
    localparam logic [OP_W-1:0] OP_SHUTDOWN   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHUT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                event_valid;
        logic                dropped_oldest;
        logic [CNT_W-1:0]    count_now;
        logic                is_empty;
        logic                is_shut;
    } t_result;

endpackage

// ===== rtl/erq_if.sv =====
// Channel interfaces of the event ring queue: the operation channel and the result channel.
// Depends on erq_pkg.
interface erq_in_if #(
    parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) ();
    logic                      valid;
    logic                      ready;
    logic [erq_pkg::OP_W-1:0]  op;
    logic [EVENT_BITS-1:0]     event_in;

    modport source(output valid, output op, output event_in, input ready);
    modport sink(input valid, input op, input event_in, output ready);
endinterface

interface erq_out_if #(
    parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [erq_pkg::STATUS_W-1:0] status;
    logic [EVENT_BITS-1:0]        event_out;
    logic                         event_valid;
    logic                         dropped_oldest;
    logic [erq_pkg::CNT_W-1:0]    count_now;
    logic                         is_empty;
    logic                         is_shut;

    modport source(output valid, output status, output event_out, output event_valid,
                   output dropped_oldest, output count_now, output is_empty,
                   output is_shut, input ready);
    modport sink(input valid, input status, input event_out, input event_valid,
                 input dropped_oldest, input count_now, input is_empty,
                 input is_shut, output ready);
endinterface

// ===== rtl/erq_slot_mem.sv =====
// Slot memory of the event ring queue: one write port and one read port with registered read data.
// Contents are not cleared by reset. Depends on erq_pkg for defaults.
module erq_slot_mem #(
    parameter int DEPTH      = erq_pkg::DEPTH_DEF,
    parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [EVENT_BITS-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [EVENT_BITS-1:0]    o_rdata
);
    logic [EVENT_BITS-1:0] r_mem [DEPTH];
    logic [EVENT_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read register holds its value until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/erq_ctrl.sv =====
// Control of the event ring queue: pointers, fill count, shutdown flag, capacity register,
// memory access issue and the stage that waits for the read data. Depends on erq_pkg.
module erq_ctrl #(
    parameter int DEPTH      = erq_pkg::DEPTH_DEF,
    parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [erq_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [erq_pkg::OP_W-1:0]   i_op,
    input  logic [EVENT_BITS-1:0]      i_event,
    output logic                       o_mem_we,
    output logic [$clog2(DEPTH)-1:0]   o_mem_waddr,
    output logic [EVENT_BITS-1:0]      o_mem_wdata,
    output logic                       o_mem_re,
    output logic [$clog2(DEPTH)-1:0]   o_mem_raddr,
    input  logic                       i_out_free,
    output logic                       o_res_valid,
    output erq_pkg::t_result           o_res
);
    import erq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] CAP_RST =
        (CAP_RESET > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(CAP_RESET);

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_shut, n_shut;
    logic             r_s1_valid;
    t_result          r_s1, n_s1;

    logic acc, s1_take, is_push, is_read, full, push_ok, read_ok;
    logic [CNT_W-1:0] cap_clamped;

    function automatic logic [CNT_W-1:0] advance(input logic [CNT_W-1:0] pos,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] nxt;
        nxt = {1'b0, pos} + (CNT_W+1)'(1);
        return (nxt >= {1'b0, cap}) ? '0 : nxt[CNT_W-1:0];
    endfunction

    always_comb begin
        if (i_cfg_data == '0) begin
            cap_clamped = CNT_W'(1);
        end else if (int'(i_cfg_data) > DEPTH) begin
            cap_clamped = CNT_W'(DEPTH);
        end else begin
            cap_clamped = i_cfg_data;
        end
    end

    assign s1_take = r_s1_valid && i_out_free;
    assign o_ready = !r_s1_valid || s1_take;
    assign acc     = i_valid && o_ready;

    assign is_push = (i_op == OP_FORCE_PUSH) || (i_op == OP_TRY_PUSH);
    assign is_read = (i_op == OP_POP) || (i_op == OP_PEEK);
    assign full    = r_cnt >= r_cap;
    assign push_ok = is_push && (i_event != '0) && !r_shut && !((i_op == OP_TRY_PUSH) && full);
    assign read_ok = is_read && (r_cnt != '0);

    assign o_mem_we    = acc && push_ok;
    assign o_mem_waddr = ADDR_W'(r_wp);
    assign o_mem_wdata = i_event;
    assign o_mem_re    = acc && read_ok;
    assign o_mem_raddr = ADDR_W'(r_rp);

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_cnt  = r_cnt;
        n_shut = r_shut;
        n_s1.status         = ST_OK;
        n_s1.event_valid    = 1'b0;
        n_s1.dropped_oldest = 1'b0;
        if (is_push) begin
            priority if (i_event == '0) begin
                n_s1.status = ST_ZERO;
            end else if (r_shut) begin
                n_s1.status = ST_SHUT;
            end else if ((i_op == OP_TRY_PUSH) && full) begin
                n_s1.status = ST_FULL;
            end else begin
                n_wp = advance(r_wp, r_cap);
                if (full) begin
                    // Overwrite: the oldest entry is lost and the read side follows the write side.
                    n_rp  = n_wp;
                    n_cnt = r_cap;
                    n_s1.dropped_oldest = 1'b1;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
        end else if (is_read) begin
            if (r_cnt == '0) begin
                n_s1.status = ST_EMPTY;
            end else begin
                n_s1.event_valid = 1'b1;
                if (i_op == OP_POP) begin
                    n_rp  = advance(r_rp, r_cap);
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
        end else if (i_op == OP_SHUTDOWN) begin
            n_shut = 1'b1;
        end
        n_s1.count_now = n_cnt;
        n_s1.is_empty  = (n_cnt == '0);
        n_s1.is_shut   = n_shut;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RST;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
            r_shut     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= cap_clamped;
                r_wp  <= '0;
                r_rp  <= '0;
                r_cnt <= '0;
            end else if (acc) begin
                r_wp   <= n_wp;
                r_rp   <= n_rp;
                r_cnt  <= n_cnt;
                r_shut <= n_shut;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
    end

    assign o_res_valid = r_s1_valid;
    assign o_res       = r_s1;
endmodule

// ===== rtl/erq_out_reg.sv =====
// Output register of the event ring queue: joins the control result with the slot read data
// and holds the transaction until the sink takes it. Depends on erq_pkg.
module erq_out_reg #(
    parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_res_valid,
    input  erq_pkg::t_result      i_res,
    input  logic [EVENT_BITS-1:0] i_rdata,
    output logic                  o_free,
    erq_out_if.source             o_res
);
    import erq_pkg::*;

    logic                  r_valid;
    t_result               r_res;
    logic [EVENT_BITS-1:0] r_event;
    logic                  load;

    assign o_free = !r_valid || o_res.ready;
    assign load   = o_free && i_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res   <= i_res;
            r_event <= i_res.event_valid ? i_rdata : '0;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.status         = r_res.status;
    assign o_res.event_out      = r_event;
    assign o_res.event_valid    = r_res.event_valid;
    assign o_res.dropped_oldest = r_res.dropped_oldest;
    assign o_res.count_now      = r_res.count_now;
    assign o_res.is_empty       = r_res.is_empty;
    assign o_res.is_shut        = r_res.is_shut;
endmodule

// ===== rtl/event_ring_queue_unit.sv =====
// Event ring queue top level: control, slot memory and output register.
// A transaction's result is registered in the control stage and then in the output register.
// Throughput: one transaction per cycle while results are taken; the memory read issued
// with a pop or peek and the single read register set this.
// Reset (synchronous, active low): pointers, count and shutdown flag clear, capacity
// returns to 16 clamped to DEPTH; the slot memory keeps its contents.
module event_ring_queue_unit #(
    parameter int DEPTH      = erq_pkg::DEPTH_DEF,
    parameter int EVENT_BITS = erq_pkg::EVENT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [erq_pkg::CNT_W-1:0] i_cfg_data,
    erq_in_if.sink                    i_cmd,
    erq_out_if.source                 o_res
);
    import erq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic                  mem_we, mem_re, out_free, res_valid;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [EVENT_BITS-1:0] mem_wdata, mem_rdata;
    t_result               res;

    erq_ctrl #(.DEPTH(DEPTH), .EVENT_BITS(EVENT_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_cmd.valid),
        .o_ready     (i_cmd.ready),
        .i_op        (i_cmd.op),
        .i_event     (i_cmd.event_in),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    erq_slot_mem #(.DEPTH(DEPTH), .EVENT_BITS(EVENT_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    erq_out_reg #(.EVENT_BITS(EVENT_BITS)) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_rdata     (mem_rdata),
        .o_free      (out_free),
        .o_res       (o_res)
    );
endmodule

// ===== test/event_ring_queue_unit_test.sv =====
// Self-checking testbench for event_ring_queue_unit: a clocked driver and monitor on the
// operation and result channels, checked against a ring-buffer predictor held in the bench.
// Depends on erq_pkg, erq_in_if, erq_out_if and the event_ring_queue_unit RTL.
module event_ring_queue_unit_test;
    import erq_pkg::*;

    localparam int EVENT_W = EVENT_BITS_DEF;
    localparam int SLOTS   = DEPTH_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int SETTLE_CYCLES = 8;

    // Op codes that the block treats as no operation.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [EVENT_W-1:0] ev;
    } t_ring_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [EVENT_W-1:0]  event_out;
        logic                event_valid;
        logic                dropped_oldest;
        logic [CNT_W-1:0]    count_now;
        logic                is_empty;
        logic                is_shut;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    erq_in_if  #(.EVENT_BITS(EVENT_W)) cmd_ch ();
    erq_out_if #(.EVENT_BITS(EVENT_W)) res_ch ();

    event_ring_queue_unit #(
        .DEPTH(SLOTS),
        .EVENT_BITS(EVENT_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_cmd(cmd_ch),
        .o_res(res_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Predictor state.
    logic [EVENT_W-1:0] ring_slots [SLOTS];
    logic [3:0]         head_wr;
    logic [3:0]         tail_rd;
    logic [CNT_W-1:0]   occupancy;
    logic               closed;
    logic [CNT_W-1:0]   cap_limit;

    t_ring_cmd cmd_backlog [$];
    t_outcome  due_outcomes [$];

    int queued_total = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int send_gap     = 0;
    int recv_stall   = 0;
    bit quiet_send   = 1'b0;
    bit quiet_recv   = 1'b0;

    int n_drops = 0;
    int n_full = 0;
    int n_shut = 0;
    int n_zero = 0;
    int n_empty = 0;
    int n_reads = 0;
    int n_cfg = 0;

    function automatic logic [3:0] ring_next(logic [3:0] pos);
        return ({1'b0, pos} + 5'd1 >= cap_limit) ? 4'd0 : pos + 4'd1;
    endfunction

    function automatic t_outcome ring_outcome(logic [OP_W-1:0] op, logic [EVENT_W-1:0] ev);
        t_outcome o;
        o = '0;
        o.status = ST_OK;
        case (op)
            OP_FORCE_PUSH, OP_TRY_PUSH: begin
                if (ev == '0) begin
                    o.status = ST_ZERO;
                end else if (closed) begin
                    o.status = ST_SHUT;
                end else if (op == OP_TRY_PUSH && occupancy >= cap_limit) begin
                    o.status = ST_FULL;
                end else begin
                    ring_slots[head_wr] = ev;
                    head_wr = ring_next(head_wr);
                    // A forcing push into a full ring loses the oldest entry.
                    if (occupancy >= cap_limit) begin
                        tail_rd = head_wr;
                        o.dropped_oldest = 1'b1;
                    end else begin
                        occupancy++;
                    end
                end
            end
            OP_POP, OP_PEEK: begin
                if (occupancy == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.event_out = ring_slots[tail_rd];
                    o.event_valid = 1'b1;
                    if (op == OP_POP) begin
                        tail_rd = ring_next(tail_rd);
                        occupancy--;
                    end
                end
            end
            OP_SHUTDOWN: begin
                closed = 1'b1;
            end
            default: ;
        endcase
        o.count_now = occupancy;
        o.is_empty = (occupancy == 0);
        o.is_shut = closed;
        case (o.status)
            ST_FULL:  n_full++;
            ST_SHUT:  n_shut++;
            ST_ZERO:  n_zero++;
            ST_EMPTY: n_empty++;
            default: ;
        endcase
        if (o.dropped_oldest) n_drops++;
        if (o.event_valid) n_reads++;
        return o;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_FORCE_PUSH : OP_TRY_PUSH;
        return ($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POP;
    endfunction

    function automatic logic [EVENT_W-1:0] pick_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 7) return '1;
        if (r < 10) return EVENT_W'(1) << $urandom_range(0, EVENT_W - 1);
        return $urandom;
    endfunction

    task automatic queue_item(logic [OP_W-1:0] op, logic [EVENT_W-1:0] ev);
        t_ring_cmd c;
        c.op = op;
        c.ev = ev;
        cmd_backlog.push_back(c);
        queued_total++;
    endtask

    // Every queued transaction has come back as a result.
    task automatic wait_idle();
        do @(posedge i_clk); while (results_seen != queued_total);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] value);
        wait_idle();
        repeat (3) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // A capacity write clears the ring but keeps the shutdown state.
        if (value == 0)
            cap_limit = CNT_W'(1);
        else if (value > SLOTS)
            cap_limit = CNT_W'(SLOTS);
        else
            cap_limit = value;
        head_wr = '0;
        tail_rd = '0;
        occupancy = '0;
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        int left;
        int burst;
        int push_pct;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 25;
                default: push_pct = 55;
            endcase
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
            repeat (burst) queue_item(pick_op(push_pct), pick_event());
            left -= burst;
            // Hold the sender back until the block has drained.
            if ($urandom_range(0, 9) == 0) wait_idle();
        end
        wait_idle();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d, %s: expected %0h, got %0h",
                         results_seen, name, want, got);
        end
    endtask

    // Driver: issues the next queued transaction once the previous one is taken.
    always @(posedge i_clk) begin
        t_ring_cmd c;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready)
                due_outcomes.push_back(ring_outcome(cmd_ch.op, cmd_ch.event_in));
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    c = cmd_backlog.pop_front();
                    cmd_ch.op <= c.op;
                    cmd_ch.event_in <= c.ev;
                    cmd_ch.valid <= 1'b1;
                    send_gap = quiet_send ? 0 : pick_gap();
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (due_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no transaction pending: status %0d count %0d",
                                 res_ch.status, res_ch.count_now);
                end else begin
                    want = due_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(res_ch.status));
                    check_field("event_out", 32'(want.event_out), 32'(res_ch.event_out));
                    check_field("event_valid", 32'(want.event_valid),
                                32'(res_ch.event_valid));
                    check_field("dropped_oldest", 32'(want.dropped_oldest),
                                32'(res_ch.dropped_oldest));
                    check_field("count_now", 32'(want.count_now), 32'(res_ch.count_now));
                    check_field("is_empty", 32'(want.is_empty), 32'(res_ch.is_empty));
                    check_field("is_shut", 32'(want.is_shut), 32'(res_ch.is_shut));
                    results_seen++;
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (!quiet_recv && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
            end
        end
    end

    initial begin
        #(64'd18_000_000);
        $display("event_ring_queue_unit verification failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op = OP_FORCE_PUSH;
        cmd_ch.event_in = '0;
        res_ch.ready = 1'b0;
        head_wr = '0;
        tail_rd = '0;
        occupancy = '0;
        closed = 1'b0;
        cap_limit = CNT_W'(CAP_RESET);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty reads, zero events, field extremes and the spare op codes.
        queue_item(OP_POP, '0);
        queue_item(OP_PEEK, '0);
        queue_item(OP_FORCE_PUSH, '0);
        queue_item(OP_TRY_PUSH, '0);
        queue_item(OP_TRY_PUSH, '1);
        queue_item(OP_FORCE_PUSH, EVENT_W'(1));
        queue_item(OP_FORCE_PUSH, EVENT_W'(1) << (EVENT_W - 1));
        queue_item(OP_PEEK, '0);
        queue_item(OP_POP, '1);
        queue_item(OP_POP, '0);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            queue_item(OP_W'(op), $urandom);
        queue_item(OP_POP, '0);
        wait_idle();

        // Directed on a single slot: overwrite, refusal when full, drain.
        write_capacity(5'd1);
        queue_item(OP_FORCE_PUSH, 32'hA5A5_5A5A);
        queue_item(OP_FORCE_PUSH, 32'h5A5A_A5A5);
        queue_item(OP_TRY_PUSH, 32'h0F0F_F0F0);
        queue_item(OP_PEEK, '0);
        queue_item(OP_POP, '0);
        queue_item(OP_POP, '0);
        wait_idle();

        write_capacity(5'd16);
        run_random(450);
        write_capacity(5'd0);
        run_random(100);
        write_capacity(5'd31);
        run_random(200);
        write_capacity(5'd2);
        run_random(150);
        write_capacity(5'd17);
        run_random(150);
        write_capacity(5'd7);
        run_random(200);
        write_capacity(5'd1);
        run_random(150);
        write_capacity(5'd16);
        run_random(350);

        // Shutdown: pushes are refused from here on while pops keep draining.
        write_capacity(5'd5);
        repeat (6) queue_item(OP_FORCE_PUSH, $urandom | EVENT_W'(1));
        queue_item(OP_TRY_PUSH, $urandom | EVENT_W'(1));
        queue_item(OP_SHUTDOWN, $urandom);
        queue_item(OP_FORCE_PUSH, $urandom | EVENT_W'(1));
        queue_item(OP_TRY_PUSH, '1);
        queue_item(OP_FORCE_PUSH, '0);
        queue_item(OP_SHUTDOWN, '0);
        queue_item(OP_PEEK, '0);
        repeat (80)
            queue_item(($urandom_range(0, 9) == 0) ? OP_SHUTDOWN : pick_op(50), pick_event());
        repeat (6) queue_item(OP_POP, '0);
        queue_item(OP_PEEK, '0);
        wait_idle();

        // A new capacity clears the ring but leaves the queue shut.
        write_capacity(5'd16);
        queue_item(OP_TRY_PUSH, $urandom | EVENT_W'(1));
        queue_item(OP_POP, '0);
        run_random(60);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_outcomes.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", due_outcomes.size());
        end
        $display("checked %0d results over %0d capacity writes, %0d events read back",
                 results_seen, n_cfg, n_reads);
        $display("overwrites %0d, full %0d, shut %0d, zero %0d, empty %0d, mismatches %0d",
                 n_drops, n_full, n_shut, n_zero, n_empty, mismatches);
        if (mismatches == 0) begin
            $display("event_ring_queue_unit verification clean");
        end else begin
            $display("event_ring_queue_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/erq_pkg.sv
rtl/erq_if.sv
rtl/erq_slot_mem.sv
rtl/erq_ctrl.sv
rtl/erq_out_reg.sv
rtl/event_ring_queue_unit.sv
test/event_ring_queue_unit_test.sv
